### design/pru_pkg.sv
// Package for the PNG row unfilter block.
// Holds sizes, the filter type codes and the item structs; used by every module.
`default_nettype none
package pru_pkg;

  localparam int MAX_ROW_BYTES       = 8192;
  localparam int MAX_BYTES_PER_PIXEL = 8;
  localparam int ADDR_W              = $clog2(MAX_ROW_BYTES);
  localparam int POS_W               = ADDR_W + 1;
  localparam int HIST_IDX_W          = $clog2(MAX_BYTES_PER_PIXEL);
  localparam int BPP_W               = 4;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  typedef struct packed {
    logic [7:0] filtered_byte;
    logic       row_start;
    logic [2:0] filter_kind;
    logic       no_above;
  } in_item_t;

  typedef struct packed {
    logic [7:0] recon_byte;
    logic       row_overflow;
  } out_item_t;

endpackage
`default_nettype wire

### design/png_row_unfilter.sv
// PNG row unfilter: reverses scanline filtering one byte per item.
// Channels: in_valid/in_stall/in_item carry one filtered byte; the first byte of
// a row has row_start set and brings the filter type and the no-above flag.
// out_valid/out_stall/out_item return the reconstructed byte and a flag that
// marks bytes past the end of the line store (those are not stored).
// cfg_wr_en/cfg_wr_data set bytes per pixel; write it only while the block is idle.
// The line store is read at the accepting edge itself, as the read stage loads; the
// predictor is then computed from the read stage and the output register loads when
// the read stage moves on, from which the result shows on out_item.
// Throughput: one item per cycle while the receiver does not stall, set by the
// single line store read port and the predictor path.
// Reset (rst_n low at a clock edge) empties both stages, clears the row position,
// selects filter none with the row above taken as zeros and sets bytes per pixel
// to one. The line store and the pixel histories hold no reset value.
// When the receiver stalls, the result holds on out_item; one more item can be
// taken into the read stage, after which in_stall rises until the result leaves.
// Depends on pru_pkg, pru_line_store and pru_predict.
`default_nettype none
module png_row_unfilter (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire pru_pkg::in_item_t in_item,
  output logic                  out_valid,
  input  wire                   out_stall,
  output pru_pkg::out_item_t    out_item,
  input  wire                   cfg_wr_en,
  input  wire [pru_pkg::BPP_W-1:0] cfg_wr_data
);
  import pru_pkg::*;

  logic [BPP_W-1:0] bpp_r;
  logic [POS_W-1:0] row_pos_r;
  logic [POS_W-1:0] row_pos_nxt;
  filt_t            held_filter_r;
  logic             held_no_above_r;

  // Read stage
  logic             s1_valid_r;
  logic [POS_W-1:0] s1_pos_r;
  logic             s1_over_r;
  filt_t            s1_filter_r;
  logic             s1_no_above_r;
  logic [7:0]       s1_byte_r;

  logic             out_valid_r;
  out_item_t        out_item_r;

  logic             in_accept;
  logic             s1_move;
  logic [POS_W-1:0] base_pos;
  logic             base_over;
  filt_t            item_filter;
  logic             item_no_above;

  logic [7:0] left_hist_r  [MAX_BYTES_PER_PIXEL];
  logic [7:0] above_hist_r [MAX_BYTES_PER_PIXEL];

  logic [BPP_W-1:0]      pix_dist;
  logic [HIST_IDX_W-1:0] dist_idx;
  logic                  past_first;
  logic [7:0]            store_rd;
  logic [7:0]            val_a;
  logic [7:0]            val_b;
  logic [7:0]            val_c;
  logic [7:0]            recon;

  assign s1_move   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_move;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    base_pos      = in_item.row_start ? '0 : row_pos_r;
    base_over     = (base_pos >= POS_W'(MAX_ROW_BYTES));
    item_filter   = in_item.row_start ? filt_t'(in_item.filter_kind) : held_filter_r;
    item_no_above = in_item.row_start ? in_item.no_above : held_no_above_r;
    row_pos_nxt   = base_over ? base_pos : base_pos + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r           <= BPP_W'(1);
      row_pos_r       <= '0;
      held_filter_r   <= FILT_NONE;
      held_no_above_r <= 1'b1;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bpp_r <= cfg_wr_data;
      end
      if (in_accept) begin
        row_pos_r       <= row_pos_nxt;
        held_filter_r   <= item_filter;
        held_no_above_r <= item_no_above;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pos_r      <= base_pos;
      s1_over_r     <= base_over;
      s1_filter_r   <= item_filter;
      s1_no_above_r <= item_no_above;
      s1_byte_r     <= in_item.filtered_byte;
    end
  end

  pru_line_store u_line_store (
    .clk     (clk),
    .wr_en   (s1_move && !s1_over_r),
    .wr_addr (s1_pos_r[ADDR_W-1:0]),
    .wr_data (recon),
    .rd_en   (in_accept && !base_over && !item_no_above),
    .rd_addr (base_pos[ADDR_W-1:0]),
    .rd_data (store_rd)
  );

  always_comb begin
    if (bpp_r == '0) begin
      pix_dist = BPP_W'(1);
    end else if (bpp_r > BPP_W'(MAX_BYTES_PER_PIXEL)) begin
      pix_dist = BPP_W'(MAX_BYTES_PER_PIXEL);
    end else begin
      pix_dist = bpp_r;
    end
    dist_idx   = HIST_IDX_W'(pix_dist - BPP_W'(1));
    past_first = (s1_pos_r >= POS_W'(pix_dist));
    val_b      = (s1_over_r || s1_no_above_r) ? 8'd0 : store_rd;
    val_a      = past_first ? left_hist_r[dist_idx]  : 8'd0;
    val_c      = past_first ? above_hist_r[dist_idx] : 8'd0;
  end

  pru_predict u_predict (
    .filter     (s1_filter_r),
    .filt_byte  (s1_byte_r),
    .left       (val_a),
    .above      (val_b),
    .above_left (val_c),
    .recon      (recon)
  );

  // Histories advance as each item completes, so the next item sees them current.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      left_hist_r[0]  <= recon;
      above_hist_r[0] <= val_b;
      for (int i = 1; i < MAX_BYTES_PER_PIXEL; i++) begin
        left_hist_r[i]  <= left_hist_r[i-1];
        above_hist_r[i] <= above_hist_r[i-1];
      end
      out_item_r.recon_byte   <= recon;
      out_item_r.row_overflow <= s1_over_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted item did not enter the read stage");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_move) |=> (s1_valid_r && $stable(s1_pos_r) && $stable(s1_byte_r)))
    else $error("blocked read stage lost its item");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_pos_r <= POS_W'(MAX_ROW_BYTES))
    else $error("row position ran past the line store");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled with the output free");

endmodule
`default_nettype wire

### design/pru_line_store.sv
// Line store that keeps the previous reconstructed row, one byte per entry.
// One write port, one registered read port with write-to-read forwarding; uses pru_pkg.
`default_nettype none
module pru_line_store (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [pru_pkg::ADDR_W-1:0] wr_addr,
  input  wire [7:0]               wr_data,
  input  wire                     rd_en,
  input  wire [pru_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]              rd_data
);
  import pru_pkg::*;

  logic [7:0] mem [MAX_ROW_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the entry being written in the same cycle takes the new byte.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### design/pru_predict.sv
// Predictor and reconstruction adder for one byte (none, sub, up, average, Paeth).
// Purely combinational; uses pru_pkg for the filter codes.
`default_nettype none
module pru_predict (
  input  wire pru_pkg::filt_t filter,
  input  wire [7:0]      filt_byte,
  input  wire [7:0]      left,
  input  wire [7:0]      above,
  input  wire [7:0]      above_left,
  output logic [7:0]     recon
);
  import pru_pkg::*;

  logic [8:0]        avg_sum;
  logic signed [9:0] dist_a;
  logic signed [9:0] dist_b;
  logic signed [9:0] dist_c;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [7:0]        paeth;
  logic [7:0]        pred;

  always_comb begin
    avg_sum = {1'b0, left} + {1'b0, above};
    // With p = a + b - c the three distances reduce to these differences.
    dist_a = $signed({2'b00, above}) - $signed({2'b00, above_left});
    dist_b = $signed({2'b00, left}) - $signed({2'b00, above_left});
    dist_c = $signed({2'b00, left}) + $signed({2'b00, above})
           - $signed({1'b0, above_left, 1'b0});
    pa = dist_a[9] ? 10'(-dist_a) : 10'(dist_a);
    pb = dist_b[9] ? 10'(-dist_b) : 10'(dist_b);
    pc = dist_c[9] ? 10'(-dist_c) : 10'(dist_c);
    if ((pa <= pb) && (pa <= pc)) begin
      paeth = left;
    end else if (pb <= pc) begin
      paeth = above;
    end else begin
      paeth = above_left;
    end

    unique case (filter)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = above;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth;
      default:    pred = 8'd0;
    endcase
    recon = filt_byte + pred;
  end

endmodule
`default_nettype wire
